/* rtl/rcs_pkg.sv */
// Shared types and constants for the record cocktail sort block.
// Used by the sorting cell, the top level and the port checker.
package rcs_pkg;

  localparam int KEY_W     = 64;
  localparam int PAYLOAD_W = 64;
  localparam int DEF_MAX_RECORDS = 32;

  // One stored record: key and the payload that travels with it
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } record_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the new item in its sorted slot
    logic shift;   // move every record one cell toward the head
  } cell_ctl_t;

endpackage

/* rtl/rcs_cell.sv */
// One cell of the sorting chain: holds a single record and its valid bit.
// Depends on rcs_pkg for record_t and cell_ctl_t.
module rcs_cell (
  input  logic               clk,
  input  logic               rst,
  input  rcs_pkg::cell_ctl_t ctl,
  input  rcs_pkg::record_t   new_rec,
  input  logic               prev_ins,
  input  rcs_pkg::record_t   prev_rec,
  input  logic               prev_valid,
  input  rcs_pkg::record_t   next_rec,
  input  logic               next_valid,
  output rcs_pkg::record_t   rec,
  output logic               valid,
  output logic               ins
);
  import rcs_pkg::*;

  // The new item belongs at or before this cell: empty, or strictly smaller
  // key (equal keys stay behind older ones, keeping the order stable)
  assign ins = !valid || (new_rec.key < rec.key);

  // Hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (ctl.insert) begin
      if (prev_ins) begin
        valid <= prev_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end
  end

  // Hold the record; take the neighbor's on a move, the new item on its slot
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rec <= next_rec;
    end else if (ctl.insert) begin
      if (prev_ins) begin
        rec <= prev_rec;
      end else if (ins) begin
        rec <= new_rec;
      end
    end
  end

endmodule

/* rtl/record_cocktail_sort_top.sv */
// Record sorter: a chain of compare cells keeps records in ascending key order.
// The last item moves the state to drain; the output register then takes the first result.
// Throughput: one record in per cycle while loading, one result out per cycle on drain when not
// stalled, set by the single broadcast compare per cell and the one-entry output register.
// Reset (rst, synchronous) empties the chain, clears the count, overflow flag and output valid.
// Items are stalled while a set drains.
module record_cocktail_sort_top #(
  parameter int MAX_RECORDS = rcs_pkg::DEF_MAX_RECORDS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rec_valid,
  output logic                          rec_stall,
  input  logic [rcs_pkg::KEY_W-1:0]     sort_key,
  input  logic [rcs_pkg::PAYLOAD_W-1:0] payload,
  input  logic                          last_record,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [rcs_pkg::KEY_W-1:0]     sorted_key,
  output logic [rcs_pkg::PAYLOAD_W-1:0] sorted_payload,
  output logic                          end_of_set,
  output logic                          records_dropped
);
  import rcs_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RECORDS);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] count;
  logic             overflow;

  record_t   new_rec;
  cell_ctl_t ctl;
  logic      rec_accept;
  logic      room;
  logic      drain_load;

  record_t cell_rec   [MAX_RECORDS];
  logic    cell_valid [MAX_RECORDS];
  logic    cell_ins   [MAX_RECORDS];

  // Handshake and chain commands
  assign rec_stall  = (state == ST_DRAIN);
  assign rec_accept = rec_valid && !rec_stall;
  assign room       = (count != CNT_FULL);
  assign drain_load = (state == ST_DRAIN) && (!res_valid || !res_stall);
  assign new_rec    = '{key: sort_key, payload: payload};
  assign ctl.insert = rec_accept && room;
  assign ctl.shift  = drain_load;

  // Build the chain of cells, head at index 0
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    record_t prev_rec;
    logic    prev_valid;
    logic    prev_ins;
    record_t next_rec;
    logic    next_valid;

    if (i == 0) begin : g_head
      assign prev_rec   = '0;
      assign prev_valid = 1'b0;
      assign prev_ins   = 1'b0;
    end else begin : g_body
      assign prev_rec   = cell_rec[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_ins   = cell_ins[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec   = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_rec   = cell_rec[i+1];
      assign next_valid = cell_valid[i+1];
    end

    rcs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_rec   (new_rec),
      .prev_ins  (prev_ins),
      .prev_rec  (prev_rec),
      .prev_valid(prev_valid),
      .next_rec  (next_rec),
      .next_valid(next_valid),
      .rec       (cell_rec[i]),
      .valid     (cell_valid[i]),
      .ins       (cell_ins[i])
    );
  end

  // Advance between loading and draining
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (rec_accept && last_record) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_load && !cell_valid[1]) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Track state, record count and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state <= state_next;
      if (drain_load && !cell_valid[1]) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (rec_accept) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  // Output register: hold a stalled result, load the chain head on drain
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drain_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_load) begin
      sorted_key      <= cell_rec[0].key;
      sorted_payload  <= cell_rec[0].payload;
      end_of_set      <= !cell_valid[1];
      records_dropped <= overflow;
    end
  end

endmodule

/* rtl/rcs_port_check.sv */
// Port-level checker for the record sorter, bound to the top level.
// Depends on rcs_pkg for field widths.
module rcs_port_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          rec_valid,
  input logic                          rec_stall,
  input logic                          last_record,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic [rcs_pkg::KEY_W-1:0]     sorted_key,
  input logic                          end_of_set
);
  import rcs_pkg::*;

  // A stalled result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(sorted_key))
    else $error("stalled result changed");

  // The item that closes a set starts the drain
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_stall && last_record |=> rec_stall)
    else $error("no drain after last item");

  // Results of a set follow back to back, in ascending key order
  a_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !end_of_set |=>
      res_valid && (sorted_key >= $past(sorted_key)))
    else $error("results out of order or gap inside a set");

  // When the final result is first shown, new items are taken again
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    res_valid && end_of_set && !$past(res_valid && res_stall) |-> !rec_stall)
    else $error("input still stalled after end of set");

endmodule

bind record_cocktail_sort_top rcs_port_check u_rcs_port_check (
  .clk        (clk),
  .rst        (rst),
  .rec_valid  (rec_valid),
  .rec_stall  (rec_stall),
  .last_record(last_record),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .sorted_key (sorted_key),
  .end_of_set (end_of_set)
);
